/* hdl/rc5_pulse_width_decoder_defines.svh */
// Assertion macros shared by the RC-5 pulse-width decoder RTL.
// Every macro samples on clk and is disabled while rst_n is low.
// Defining ASSERT_OFF turns every macro into an empty line.
`ifndef RC5_PULSE_WIDTH_DECODER_DEFINES_SVH
`define RC5_PULSE_WIDTH_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge outside reset.
`define RC5PWD_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rc5pwd: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define RC5PWD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc5pwd: same-cycle implication violated");

// The consequent holds in the cycle after the antecedent.
`define RC5PWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc5pwd: next-cycle implication violated");

`else

`define RC5PWD_ASSERT_ALWAYS(label, cond)
`define RC5PWD_ASSERT_IMPLIES(label, ante, cons)
`define RC5PWD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/rc5pwd_pkg.sv */
// Package of the RC-5 pulse-width decoder: widths, register codes, reset
// values and the item and control structs. It depends on nothing else.

package rc5pwd_pkg;

    // Widths of time values, input fields and configuration words.
    localparam int TIME_WIDTH = 16;
    localparam int DURATION_W = 16;
    localparam int CFG_W      = 16;
    localparam int CMP_W      = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    // Half-bit store and frame layout.
    localparam int HALF_BIT_MAX = 28;
    localparam int HB_W         = HALF_BIT_MAX;
    localparam int HB_CNT_W     = 5;
    localparam int FRAME_BITS   = 13;
    localparam int ADDR_W       = 5;
    localparam int CMD_W        = 6;
    localparam logic [HB_CNT_W-1:0] HB_COUNT_SHORT = HB_CNT_W'(26);
    localparam logic [HB_CNT_W-1:0] HB_COUNT_LONG  = HB_CNT_W'(27);

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [CFG_W-1:0]      cfg_word_t;

    localparam time_t TIME_MAX = '1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 3'd5;

    // Register values after reset.
    localparam cfg_word_t RST_NOISE_MIN   = 16'd750;
    localparam cfg_word_t RST_SINGLE_LOW  = 16'd800;
    localparam cfg_word_t RST_SINGLE_HIGH = 16'd1000;
    localparam cfg_word_t RST_DOUBLE_LOW  = 16'd1600;
    localparam cfg_word_t RST_DOUBLE_HIGH = 16'd2000;
    localparam logic      RST_INVERT      = 1'b0;

    // Number of half-bits that one classified segment yields.
    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef struct packed {
        cfg_word_t noise_min_us;
        cfg_word_t single_low_us;
        cfg_word_t single_high_us;
        cfg_word_t double_low_us;
        cfg_word_t double_high_us;
        logic      invert_level;
    } cfg_t;

    typedef struct packed {
        logic                  level;
        logic [DURATION_W-1:0] duration_us;
        logic                  frame_end;
    } seg_item_t;

    typedef struct packed {
        logic              frame_valid;
        logic              toggle_bit;
        logic [ADDR_W-1:0] address;
        logic [CMD_W-1:0]  command;
    } res_item_t;

    // Merged segment that still waits for classification.
    typedef struct packed {
        logic  valid;
        logic  level;
        time_t length;
    } pend_t;

    // Half-bits produced by classifying the pending segment.
    typedef struct packed {
        logic [1:0] count;
        logic       value;
    } push_t;

endpackage

/* hdl/rc5pwd_classify.sv */
// Window classifier of the RC-5 pulse-width decoder: turns the pending
// segment into zero, one or two half-bits. Depends on rc5pwd_pkg.

module rc5pwd_classify (
    input  rc5pwd_pkg::cfg_t  cfg,
    input  rc5pwd_pkg::pend_t pend,
    output rc5pwd_pkg::push_t push
);
    import rc5pwd_pkg::*;

    logic [CMP_W-1:0] len;
    logic             in_single;
    logic             in_double;

    // Both windows are open at either end.
    assign len       = CMP_W'(pend.length);
    assign in_single = (len > CMP_W'(cfg.single_low_us)) && (len < CMP_W'(cfg.single_high_us));
    assign in_double = (len > CMP_W'(cfg.double_low_us)) && (len < CMP_W'(cfg.double_high_us));

    // The single window takes priority when the windows overlap.
    always_comb
    begin
        push.value = pend.level ^ cfg.invert_level;
        if (!pend.valid)
        begin
            push.count = PUSH_NONE;
        end
        else if (in_single)
        begin
            push.count = PUSH_ONE;
        end
        else if (in_double)
        begin
            push.count = PUSH_TWO;
        end
        else
        begin
            push.count = PUSH_NONE;
        end
    end

endmodule

/* hdl/rc5_pulse_width_decoder.sv */
// Top level of the RC-5 pulse-width decoder: input register, segment and
// half-bit state, frame unpacking and result register.
// Depends on rc5pwd_pkg, rc5pwd_classify and the assertion macro header.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ---------------------------------------
//  segment   seg_valid / seg_stall   seg_item: level, duration_us, frame_end
//  result    res_valid / res_stall   res_item: frame_valid, toggle_bit, ...
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per clock cycle while seg_stall is low; the input register takes an
// item, and the frame state and result register are written when it retires.
// An end-of-frame item waits in the input register only while the result
// register is full and stalled; segment items never wait.
// Reset restores the register defaults and clears all frame state; there is
// no clearing pass. Configuration writes are always ready.

`include "rc5_pulse_width_decoder_defines.svh"

module rc5_pulse_width_decoder (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       seg_valid,
    output logic                                       seg_stall,
    input  rc5pwd_pkg::seg_item_t                      seg_item,
    output logic                                       res_valid,
    input  logic                                       res_stall,
    output rc5pwd_pkg::res_item_t                      res_item,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [rc5pwd_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [rc5pwd_pkg::CFG_W-1:0]               cfg_data
);
    import rc5pwd_pkg::*;

    // Saturating sum of two time values.
    function automatic time_t sat_add(time_t a, time_t b);
        logic [TIME_WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
    endfunction

    // Brings a duration to the time width, saturating if it does not fit.
    function automatic time_t fit_dur(logic [DURATION_W-1:0] d);
        logic [DURATION_W+TIME_WIDTH-1:0] wide;
        wide = (DURATION_W + TIME_WIDTH)'(d);
        return (wide > (DURATION_W + TIME_WIDTH)'(TIME_MAX)) ? TIME_MAX : time_t'(wide);
    endfunction

    cfg_t                  cfg_reg;
    seg_item_t             seg_reg;
    logic                  seg_vld_reg;
    res_item_t             res_reg;
    res_item_t             res_next;
    logic                  res_vld_reg;
    time_t                 noise_reg;
    time_t                 noise_next;
    pend_t                 pend_reg;
    pend_t                 pend_next;
    logic [HB_W-1:0]       half_bits_reg;
    logic [HB_W-1:0]       half_bits_next;
    logic [HB_CNT_W-1:0]   half_cnt_reg;
    logic [HB_CNT_W-1:0]   half_cnt_next;

    logic                  advance;
    push_t                 push;
    time_t                 dur;
    time_t                 noise_total;
    time_t                 pend_total;
    logic                  is_noise;
    logic [HB_W-1:0]       hb_push;
    logic [HB_CNT_W-1:0]   cnt_push;
    logic [FRAME_BITS-1:0] frame_bits;
    logic                  frame_ok;
    logic                  frame_idle;

    // Configuration registers; writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.noise_min_us   <= RST_NOISE_MIN;
            cfg_reg.single_low_us  <= RST_SINGLE_LOW;
            cfg_reg.single_high_us <= RST_SINGLE_HIGH;
            cfg_reg.double_low_us  <= RST_DOUBLE_LOW;
            cfg_reg.double_high_us <= RST_DOUBLE_HIGH;
            cfg_reg.invert_level   <= RST_INVERT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NOISE_MIN:   cfg_reg.noise_min_us   <= cfg_data;
                CFG_SINGLE_LOW:  cfg_reg.single_low_us  <= cfg_data;
                CFG_SINGLE_HIGH: cfg_reg.single_high_us <= cfg_data;
                CFG_DOUBLE_LOW:  cfg_reg.double_low_us  <= cfg_data;
                CFG_DOUBLE_HIGH: cfg_reg.double_high_us <= cfg_data;
                CFG_INVERT:      cfg_reg.invert_level   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // The held item retires unless it ends a frame and the result slot is blocked.
    assign advance   = seg_vld_reg && (!seg_reg.frame_end || !res_vld_reg || !res_stall);
    assign seg_stall = seg_vld_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_vld_reg <= 1'b0;
        end
        else if (seg_valid && !seg_stall)
        begin
            seg_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            seg_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_valid && !seg_stall)
        begin
            seg_reg <= seg_item;
        end
    end

    // Classification of the pending segment.
    rc5pwd_classify u_classify (
        .cfg  (cfg_reg),
        .pend (pend_reg),
        .push (push)
    );

    // Appends the classified half-bits, dropping any beyond the store size.
    always_comb
    begin
        hb_push  = half_bits_reg;
        cnt_push = half_cnt_reg;
        for (int k = 0; k < 2; k++)
        begin
            if ((2'(k) < push.count) && (cnt_push < HB_CNT_W'(HALF_BIT_MAX)))
            begin
                hb_push  = hb_push | (HB_W'(push.value) << cnt_push);
                cnt_push = cnt_push + HB_CNT_W'(1);
            end
        end
    end

    // Frame unpacking: skip the first half-bit, take the first of each pair.
    always_comb
    begin
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            frame_bits[FRAME_BITS-1-i] = hb_push[1 + 2 * i];
        end
        frame_ok = (cnt_push == HB_COUNT_SHORT) || (cnt_push == HB_COUNT_LONG);
        res_next.frame_valid = frame_ok;
        res_next.toggle_bit  = frame_ok & frame_bits[ADDR_W+CMD_W];
        res_next.address     = frame_ok ? frame_bits[ADDR_W+CMD_W-1:CMD_W] : '0;
        res_next.command     = frame_ok ? frame_bits[CMD_W-1:0] : '0;
    end

    // Segment merging and next frame state.
    assign dur         = fit_dur(seg_reg.duration_us);
    assign noise_total = sat_add(noise_reg, dur);
    assign pend_total  = sat_add(pend_reg.length, noise_total);
    assign is_noise    = CMP_W'(dur) < CMP_W'(cfg_reg.noise_min_us);

    always_comb
    begin
        noise_next     = noise_reg;
        pend_next      = pend_reg;
        half_bits_next = half_bits_reg;
        half_cnt_next  = half_cnt_reg;
        if (advance)
        begin
            if (seg_reg.frame_end)
            begin
                noise_next     = '0;
                pend_next      = '0;
                half_bits_next = '0;
                half_cnt_next  = '0;
            end
            else if (is_noise)
            begin
                noise_next = noise_total;
            end
            else
            begin
                noise_next = '0;
                if (pend_reg.valid && (pend_reg.level == seg_reg.level))
                begin
                    pend_next.length = pend_total;
                end
                else
                begin
                    half_bits_next   = hb_push;
                    half_cnt_next    = cnt_push;
                    pend_next.valid  = 1'b1;
                    pend_next.level  = seg_reg.level;
                    pend_next.length = noise_total;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg     <= '0;
            pend_reg      <= '0;
            half_bits_reg <= '0;
            half_cnt_reg  <= '0;
        end
        else
        begin
            noise_reg     <= noise_next;
            pend_reg      <= pend_next;
            half_bits_reg <= half_bits_next;
            half_cnt_reg  <= half_cnt_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance && seg_reg.frame_end)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (res_vld_reg && !res_stall)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && seg_reg.frame_end)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_vld_reg;
    assign res_item  = res_reg;

    // Frame state as it stands between frames.
    assign frame_idle = (half_cnt_reg == '0) && !pend_reg.valid && (noise_reg == '0);

    // The half-bit count never passes the store size.
    `RC5PWD_ASSERT_ALWAYS(a_count_bound, half_cnt_reg <= HB_CNT_W'(HALF_BIT_MAX))
    // Ending a frame loads a result and clears the frame state.
    `RC5PWD_ASSERT_NEXT(a_frame_clears, advance && seg_reg.frame_end, res_vld_reg && frame_idle)
    // Only an end-of-frame item facing a blocked result slot holds the input.
    `RC5PWD_ASSERT_IMPLIES(a_stall_cause, seg_stall, seg_vld_reg && seg_reg.frame_end && res_vld_reg && res_stall)

endmodule

/* verif/tb_rc5_pulse_width_decoder.sv */
// Self-checking testbench for the RC-5 pulse-width decoder: directed rows, then
// Manchester frames with random content and noise, checked against a local predictor.
// Depends on rc5pwd_pkg and the rc5_pulse_width_decoder RTL.

module tb_rc5_pulse_width_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import rc5pwd_pkg::*;

    localparam int ITEMS_PER_PHASE = 130;
    localparam int NUM_PHASES      = 8;
    localparam int REPORT_LIMIT    = 10;
    localparam int SETTLE_CYCLES   = 4;
    localparam res_item_t NO_FRAME = '0;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct packed {
        seg_item_t item;
        logic      typed;
        res_item_t want;
    } step_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 seg_valid;
    logic                 seg_stall;
    seg_item_t            seg_item;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    res_item_t            res_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Predictor state: register shadow and frame under construction.
    cfg_t                cfg_shadow;
    time_t               noise_time;
    pend_t               open_seg;
    logic [HB_W-1:0]     half_bits;
    logic [HB_CNT_W-1:0] half_count;
    res_item_t           frames_due[$];

    int        fault_count   = 0;
    int        phase_items   = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    step_row_t step_rows [24];

    rc5_pulse_width_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg_item  (seg_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic time_t sat_sum(time_t a, time_t b);
        logic [TIME_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_WIDTH] ? TIME_MAX : s[TIME_WIDTH-1:0];
    endfunction

    function automatic void clear_frame();
        noise_time = '0;
        open_seg   = '0;
        half_bits  = '0;
        half_count = '0;
    endfunction

    // Turn the open segment into zero, one or two half-bits.
    function automatic void close_segment();
        logic value;
        int   pushes;
        if (!open_seg.valid)
            return;
        value  = open_seg.level ^ cfg_shadow.invert_level;
        pushes = 0;
        if (open_seg.length > cfg_shadow.single_low_us &&
            open_seg.length < cfg_shadow.single_high_us)
            pushes = 1;
        else if (open_seg.length > cfg_shadow.double_low_us &&
                 open_seg.length < cfg_shadow.double_high_us)
            pushes = 2;
        repeat (pushes)
        begin
            if (half_count < HB_CNT_W'(HALF_BIT_MAX))
            begin
                half_bits[half_count] = value;
                half_count++;
            end
        end
        open_seg.valid = 1'b0;
    endfunction

    // Advance the predictor by one accepted item; a frame end queues a result.
    function automatic void decode_segment(seg_item_t it);
        time_t                 total;
        res_item_t             frame;
        logic [FRAME_BITS-1:0] bits;
        if (!it.frame_end)
        begin
            if (it.duration_us < cfg_shadow.noise_min_us)
            begin
                noise_time = sat_sum(noise_time, it.duration_us);
                return;
            end
            total      = sat_sum(noise_time, it.duration_us);
            noise_time = '0;
            if (open_seg.valid && open_seg.level == it.level)
                open_seg.length = sat_sum(open_seg.length, total);
            else
            begin
                close_segment();
                open_seg.valid  = 1'b1;
                open_seg.level  = it.level;
                open_seg.length = total;
            end
            return;
        end
        close_segment();
        frame = NO_FRAME;
        if (half_count == HB_COUNT_SHORT || half_count == HB_COUNT_LONG)
        begin
            // Skip the first half-bit, then take the first half of each pair.
            bits = '0;
            for (int i = 0; i < FRAME_BITS; i++)
                bits = {bits[FRAME_BITS-2:0], half_bits[1 + 2 * i]};
            frame.frame_valid = 1'b1;
            frame.toggle_bit  = bits[11];
            frame.address     = bits[10:6];
            frame.command     = bits[5:0];
        end
        frames_due.push_back(frame);
        clear_frame();
    endfunction

    function automatic seg_item_t seg_of(logic fe, logic lvl, int unsigned dur);
        seg_item_t it;
        it.level       = lvl;
        it.duration_us = DURATION_W'(dur);
        it.frame_end   = fe;
        return it;
    endfunction

    function automatic step_row_t mk_row(logic fe, logic lvl, int unsigned dur,
                                         logic typed, res_item_t want);
        step_row_t row;
        row.item  = seg_of(fe, lvl, dur);
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // Register settings of each random phase, extremes included.
    function automatic cfg_t phase_config(int p);
        cfg_t c;
        case (p)
            0: c = '{RST_NOISE_MIN, RST_SINGLE_LOW, RST_SINGLE_HIGH,
                     RST_DOUBLE_LOW, RST_DOUBLE_HIGH, 1'b1};
            1: c = '{16'd0, 16'd0, 16'd400, 16'd600, 16'hFFFF, 1'b0};
            2: c = '{16'd100, 16'd200, 16'd400, 16'd500, 16'd700, 1'b0};
            4: c = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1};
            5: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
            6: c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0};
            7: c = '{RST_NOISE_MIN, RST_SINGLE_LOW, RST_SINGLE_HIGH,
                     RST_DOUBLE_LOW, RST_DOUBLE_HIGH, 1'b0};
            default:
            begin
                // Random but ordered windows that still decode real frames.
                c.noise_min_us   = CFG_W'($urandom_range(0, 2000));
                c.single_low_us  = c.noise_min_us + CFG_W'($urandom_range(0, 300));
                c.single_high_us = c.single_low_us + CFG_W'($urandom_range(2, 1000));
                c.double_low_us  = c.single_high_us + CFG_W'($urandom_range(0, 1000));
                c.double_high_us = c.double_low_us + CFG_W'($urandom_range(2, 3000));
                c.invert_level   = 1'($urandom);
            end
        endcase
        return c;
    endfunction

    // Present one item and wait until it is taken; returns at that rising edge.
    task automatic send_item(seg_item_t it);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            seg_valid <= 1'b0;
            @(negedge clk);
        end
        seg_valid <= 1'b1;
        seg_item  <= it;
        do
            @(posedge clk);
        while (seg_stall);
        decode_segment(it);
        phase_items++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_NOISE_MIN:   cfg_shadow.noise_min_us   = data;
            CFG_SINGLE_LOW:  cfg_shadow.single_low_us  = data;
            CFG_SINGLE_HIGH: cfg_shadow.single_high_us = data;
            CFG_DOUBLE_LOW:  cfg_shadow.double_low_us  = data;
            CFG_DOUBLE_HIGH: cfg_shadow.double_high_us = data;
            CFG_INVERT:      cfg_shadow.invert_level   = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(cfg_t c);
        cfg_write(CFG_NOISE_MIN, c.noise_min_us);
        cfg_write(CFG_SINGLE_LOW, c.single_low_us);
        cfg_write(CFG_SINGLE_HIGH, c.single_high_us);
        cfg_write(CFG_DOUBLE_LOW, c.double_low_us);
        cfg_write(CFG_DOUBLE_HIGH, c.double_high_us);
        // Upper bits of the invert word are junk that the block must ignore.
        cfg_write(CFG_INVERT, {(CFG_W-1)'($urandom), c.invert_level});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender off until every queued frame result is back and settled.
    task automatic drain();
        @(negedge clk);
        seg_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One segment of a run; sometimes preceded by noise or split in two.
    task automatic send_segment(logic lvl, int run, bit broken);
        int          lo;
        int          hi;
        int unsigned dur;
        int unsigned cut;
        if ($urandom_range(9) == 0 && cfg_shadow.noise_min_us != 0)
            send_item(seg_of(1'b0, 1'($urandom),
                             $urandom_range(0, int'(cfg_shadow.noise_min_us) - 1)));
        lo = (run == 2) ? int'(cfg_shadow.double_low_us) : int'(cfg_shadow.single_low_us);
        hi = (run == 2) ? int'(cfg_shadow.double_high_us) : int'(cfg_shadow.single_high_us);
        if ((broken && $urandom_range(4) == 0) || hi <= lo + 1)
            dur = $urandom_range(0, 65535);
        else
            dur = $urandom_range(lo + 1, hi - 1);
        if ($urandom_range(9) == 0)
        begin
            cut = $urandom_range(0, dur);
            send_item(seg_of(1'b0, lvl, cut));
            send_item(seg_of(1'b0, lvl, dur - cut));
        end
        else
            send_item(seg_of(1'b0, lvl, dur));
    endtask

    // A Manchester frame of 26 or 27 half-bits, or a broken one of random length.
    task automatic send_frame(bit broken);
        logic                  halves[$];
        logic [FRAME_BITS-1:0] word;
        int                    idx;
        int                    run;
        if (!broken)
        begin
            word = FRAME_BITS'($urandom);
            halves.push_back(1'($urandom));
            for (int i = FRAME_BITS - 1; i >= 0; i--)
            begin
                halves.push_back(word[i]);
                halves.push_back(!word[i]);
            end
            if ($urandom_range(1) == 1)
                void'(halves.pop_back());
        end
        else
            repeat ($urandom_range(0, 31)) halves.push_back(1'($urandom));
        idx = 0;
        while (idx < halves.size())
        begin
            run = (idx + 1 < halves.size() && halves[idx + 1] == halves[idx]) ? 2 : 1;
            send_segment(halves[idx] ^ cfg_shadow.invert_level, run, broken);
            idx += run;
        end
        // Noise left at the end of a frame must be thrown away.
        if ($urandom_range(3) == 0 && cfg_shadow.noise_min_us != 0)
            send_item(seg_of(1'b0, 1'($urandom),
                             $urandom_range(0, int'(cfg_shadow.noise_min_us) - 1)));
        send_item(seg_of(1'b1, 1'($urandom), $urandom_range(0, 65535)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_item(seg_of($urandom_range(7) == 0, 1'($urandom), $urandom_range(0, 65535)));
    endtask

    // Compare every result item taken with the oldest expected frame.
    always @(posedge clk)
    begin : check_results
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (frames_due.size() == 0)
            begin
                if (fault_count < REPORT_LIMIT)
                    $display("unexpected result item: valid %0b toggle %0b addr %0d cmd %0d",
                             res_item.frame_valid, res_item.toggle_bit,
                             res_item.address, res_item.command);
                fault_count++;
            end
            else
            begin
                want = frames_due.pop_front();
                if (res_item.frame_valid !== want.frame_valid ||
                    res_item.toggle_bit !== want.toggle_bit ||
                    res_item.address !== want.address ||
                    res_item.command !== want.command)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("frame mismatch (exp/got): valid %0b/%0b toggle %0b/%0b %s",
                                 want.frame_valid, res_item.frame_valid,
                                 want.toggle_bit, res_item.toggle_bit,
                                 $sformatf("addr %0d/%0d cmd %0d/%0d",
                                           want.address, res_item.address,
                                           want.command, res_item.command));
                    fault_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb_rc5_pulse_width_decoder: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int pick;
        rst_n      = 1'b0;
        seg_valid  = 1'b0;
        seg_item   = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_NOISE_MIN;
        cfg_data   = '0;
        cfg_shadow = '{RST_NOISE_MIN, RST_SINGLE_LOW, RST_SINGLE_HIGH,
                       RST_DOUBLE_LOW, RST_DOUBLE_HIGH, RST_INVERT};
        clear_frame();

        // Directed rows under the reset settings: empty frame, saturating
        // noise and merged lengths, then too many half-bits with trailing noise.
        step_rows = '{
            mk_row(1'b1, 1'b0, 0,     1'b1, NO_FRAME),
            mk_row(1'b0, 1'b1, 0,     1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 749,   1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 749,   1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 65535, 1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 65535, 1'b0, NO_FRAME),
            mk_row(1'b1, 1'b1, 65535, 1'b1, NO_FRAME),
            mk_row(1'b0, 1'b0, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b0, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b0, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b0, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b0, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b0, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b0, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b0, 1800,  1'b0, NO_FRAME),
            mk_row(1'b0, 1'b1, 100,   1'b0, NO_FRAME),
            mk_row(1'b1, 1'b0, 0,     1'b1, NO_FRAME)
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 8;
        stall_pct     = 70;
        foreach (step_rows[k])
        begin
            send_item(step_rows[k].item);
            if (step_rows[k].item.frame_end && step_rows[k].typed)
                frames_due[frames_due.size() - 1] = step_rows[k].want;
        end
        drain();

        // Random phases: each one reprograms the block while it is idle.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = (p < 3) ? 8 : (p < 6) ? 70 : 0;
            stall_pct     = (p < 3) ? 70 : (p < 6) ? 8 : 0;
            apply_config(phase_config(p));
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_frame(1'b0);
                else if (pick < 85)
                    send_frame(1'b1);
                else
                    send_noise();
            end
            drain();
        end

        if (fault_count == 0)
            $display("tb_rc5_pulse_width_decoder: done, clean");
        else
            $display("tb_rc5_pulse_width_decoder: done, errors");
        $finish;
    end

endmodule
